@@ hw/rtl/modbus_response_parser_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus reply parser checker
// ----------------------------------------------------------------------------
`ifndef MODBUS_RESPONSE_PARSER_MACROS_SVH
`define MODBUS_RESPONSE_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mrp_pkg.sv @@
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared types, constants and the CRC-16 byte update for the reply parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrp_pkg;

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_LOAD_CODE      = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_SWITCH_CODE    = 2'd2;

    localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h01;
    localparam logic [7:0] LOAD_CODE_RESET      = 8'h03;
    localparam logic [7:0] SWITCH_CODE_RESET    = 8'h02;

    // Result status codes
    localparam logic [2:0] ST_SWITCH_OFF = 3'd0;
    localparam logic [2:0] ST_SWITCH_ON  = 3'd1;
    localparam logic [2:0] ST_LOAD_OK    = 3'd2;
    localparam logic [2:0] ST_CRC_ERROR  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN    = 3'd4;
    localparam logic [2:0] ST_BAD_SWITCH = 3'd5;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL   = 16'hA001;
    localparam logic [31:0] LOAD_LIMIT      = 32'hF000_0000;
    localparam logic [7:0]  SWITCH_ON_VALUE = 8'h01;

    localparam logic [3:0] SWITCH_FRAME_LEN = 4'd6;
    localparam logic [3:0] LOAD_FRAME_LEN   = 4'd9;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] load_code;
        logic [7:0] switch_code;
    } cfg_t;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_CODE = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    // Frame outcome handed from the parser front to the result back end
    typedef enum logic [1:0] {
        REC_UNKNOWN = 2'd0,
        REC_CRC_BAD = 2'd1,
        REC_LOAD    = 2'd2,
        REC_SWITCH  = 2'd3
    } rec_kind_t;

    typedef struct packed {
        rec_kind_t   kind;
        logic [31:0] payload;
    } rec_t;

    // One byte through the reflected Modbus CRC-16
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/mrp_front.sv @@
// ----------------------------------------------------------------------------
// mrp_front
// Byte framer: address hunt, code decode, CRC-16 and payload capture.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrp_front
    import mrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    input  logic       q_full,
    output logic       q_push,
    output rec_t       q_data
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic        is_load_reg, is_load_next;
    logic [31:0] payload_reg, payload_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    logic       accept;
    logic       code_known;
    logic [3:0] frame_len;
    logic [3:0] crc_lo_pos;
    logic [3:0] crc_hi_pos;
    logic       go_hunt;

    assign rx_ready   = !q_full;
    assign accept     = rx_valid && rx_ready;
    assign code_known = (rx_byte == cfg.switch_code) || (rx_byte == cfg.load_code);
    assign frame_len  = is_load_reg ? LOAD_FRAME_LEN : SWITCH_FRAME_LEN;
    assign crc_lo_pos = frame_len - 4'd2;
    assign crc_hi_pos = frame_len - 4'd1;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_CODE: phase_next = code_known ? PH_BODY : PH_HUNT;
                PH_BODY: phase_next = (count_reg < crc_hi_pos) ? PH_BODY : PH_HUNT;
                default: phase_next = (rx_byte == cfg.device_address) ? PH_CODE : PH_HUNT;
            endcase
        end
    end

    // Datapath and queue write
    always_comb
    begin
        count_next   = count_reg;
        crc_next     = crc_reg;
        is_load_next = is_load_reg;
        payload_next = payload_reg;
        crc_low_next = crc_low_reg;
        go_hunt      = 1'b0;
        q_push       = 1'b0;
        q_data.kind    = REC_UNKNOWN;
        q_data.payload = payload_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_CODE:
                begin
                    crc_next = crc_feed(crc_reg, rx_byte);
                    // switch code wins when both codes are equal
                    if (rx_byte == cfg.switch_code)
                    begin
                        is_load_next = 1'b0;
                        count_next   = 4'd2;
                    end
                    else if (rx_byte == cfg.load_code)
                    begin
                        is_load_next = 1'b1;
                        count_next   = 4'd2;
                    end
                    else
                    begin
                        q_push  = 1'b1;
                        go_hunt = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    if (count_reg < crc_lo_pos)
                    begin
                        crc_next     = crc_feed(crc_reg, rx_byte);
                        payload_next = {payload_reg[23:0], rx_byte};
                        count_next   = count_reg + 4'd1;
                    end
                    else if (count_reg == crc_lo_pos)
                    begin
                        crc_low_next = rx_byte;
                        count_next   = count_reg + 4'd1;
                    end
                    else if (count_reg == crc_hi_pos)
                    begin
                        q_push  = 1'b1;
                        go_hunt = 1'b1;
                        if ({rx_byte, crc_low_reg} != crc_reg)
                            q_data.kind = REC_CRC_BAD;
                        else if (is_load_reg)
                            q_data.kind = REC_LOAD;
                        else
                            q_data.kind = REC_SWITCH;
                    end
                    else
                    begin
                        go_hunt = 1'b1;
                    end
                end
                default:
                begin
                    if (rx_byte == cfg.device_address)
                    begin
                        crc_next     = crc_feed(CRC_INIT, rx_byte);
                        count_next   = 4'd1;
                        is_load_next = 1'b0;
                        payload_next = '0;
                        crc_low_next = '0;
                    end
                    else
                    begin
                        go_hunt = 1'b1;
                    end
                end
            endcase
            if (go_hunt)
            begin
                count_next   = '0;
                crc_next     = CRC_INIT;
                is_load_next = 1'b0;
                payload_next = '0;
                crc_low_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            count_reg   <= '0;
            crc_reg     <= CRC_INIT;
            is_load_reg <= 1'b0;
            payload_reg <= '0;
            crc_low_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            is_load_reg <= is_load_next;
            payload_reg <= payload_next;
            crc_low_reg <= crc_low_next;
        end
    end

endmodule

@@ hw/rtl/mrp_fifo.sv @@
// ----------------------------------------------------------------------------
// mrp_fifo
// Short queue of frame outcomes between the framer and the result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrp_fifo
    import mrp_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t din,
    input  logic pop,
    output rec_t dout,
    output logic full,
    output logic empty
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);
    localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
    localparam logic [CntW-1:0] CntOne  = CntW'(1);

    rec_t            mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CntFull);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + PtrOne;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + PtrOne;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CntOne;
            2'b01:   count_next = count_reg - CntOne;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/mrp_back.sv @@
// ----------------------------------------------------------------------------
// mrp_back
// Result stage: load word swap and limit, switch decode, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrp_back
    import mrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  rec_t        q_data,
    output logic        q_pop,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [2:0]  status,
    output logic [31:0] load_value,
    output logic        switch_on
);

    logic        res_valid_reg, res_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] load_value_reg, load_value_next;
    logic        switch_on_reg, switch_on_next;

    logic [31:0] load_swapped;
    logic [7:0]  switch_val;

    // payload holds d3..d6 with d6 lowest; load is d5 d6 d3 d4 from the top
    assign load_swapped = {q_data.payload[15:0], q_data.payload[31:16]};
    assign switch_val   = q_data.payload[7:0];

    assign q_pop = !q_empty && (!res_valid_reg || res_ready);

    always_comb
    begin
        status_next     = ST_UNKNOWN;
        load_value_next = '0;
        switch_on_next  = 1'b0;
        unique case (q_data.kind)
            REC_UNKNOWN: status_next = ST_UNKNOWN;
            REC_CRC_BAD: status_next = ST_CRC_ERROR;
            REC_LOAD:
            begin
                status_next     = ST_LOAD_OK;
                load_value_next = (load_swapped > LOAD_LIMIT) ? '0 : load_swapped;
            end
            default:
            begin
                if (switch_val == SWITCH_ON_VALUE)
                begin
                    status_next    = ST_SWITCH_ON;
                    switch_on_next = 1'b1;
                end
                else if (switch_val == 8'h00)
                    status_next = ST_SWITCH_OFF;
                else
                    status_next = ST_BAD_SWITCH;
            end
        endcase
    end

    always_comb
    begin
        if (q_pop)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg     <= status_next;
            load_value_reg <= load_value_next;
            switch_on_reg  <= switch_on_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign status     = status_reg;
    assign load_value = load_value_reg;
    assign switch_on  = switch_on_reg;

endmodule

@@ hw/rtl/modbus_response_parser.sv @@
// ----------------------------------------------------------------------------
// modbus_response_parser
// Modbus RTU reply parser: address hunt, switch/load replies, CRC-16 check.
// Throughput: one received byte per cycle while the queue is not full;
// the CRC update is one byte a cycle. A frame's outcome is written into
// the queue, then into the result register, where it becomes visible.
// Stall: bytes keep flowing while results back up until the queue is full.
// Reset: asynchronous, active low; parser hunts, control registers take reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_response_parser
    import mrp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               rx_valid,
    output logic               rx_ready,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [2:0]         status,
    output logic [31:0]        load_value,
    output logic               switch_on
);

    cfg_t cfg_reg, cfg_next;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    rec_t q_wr_data;
    rec_t q_rd_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_next.device_address = cfg_data;
                CFG_LOAD_CODE:      cfg_next.load_code      = cfg_data;
                CFG_SWITCH_CODE:    cfg_next.switch_code    = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= DEVICE_ADDRESS_RESET;
            cfg_reg.load_code      <= LOAD_CODE_RESET;
            cfg_reg.switch_code    <= SWITCH_CODE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mrp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    mrp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_wr_data),
        .pop   (q_pop),
        .dout  (q_rd_data),
        .full  (q_full),
        .empty (q_empty)
    );

    mrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_rd_data),
        .q_pop      (q_pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .status     (status),
        .load_value (load_value),
        .switch_on  (switch_on)
    );

endmodule

@@ hw/rtl/mrp_checker.sv @@
// ----------------------------------------------------------------------------
// mrp_checker
// Port-level checks on the reply parser's result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "modbus_response_parser_macros.svh"

module mrp_checker
    import mrp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  status,
    input logic [31:0] load_value,
    input logic        switch_on
);

    `MRP_ASSERT_NOW(a_status_range, res_valid, status <= ST_BAD_SWITCH,
        "status code out of range")
    `MRP_ASSERT_NOW(a_load_zero, res_valid && (status != ST_LOAD_OK), load_value == '0,
        "load_value set on a non-load result")
    `MRP_ASSERT_NOW(a_switch_flag, res_valid, switch_on == (status == ST_SWITCH_ON),
        "switch_on disagrees with status")
    `MRP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
        res_valid && $stable(status) && $stable(load_value) && $stable(switch_on),
        "stalled result changed")

endmodule

bind modbus_response_parser mrp_checker u_mrp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .status     (status),
    .load_value (load_value),
    .switch_on  (switch_on)
);

@@ bench/modbus_response_parser_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus reply parser checker
// Watches the byte and result channels, predicts each result from the bytes
// taken and the register writes seen, and compares field by field.
// ----------------------------------------------------------------------------

module modbus_response_parser_checker
    import mrp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               rx_valid,
    input  logic               rx_ready,
    input  logic [7:0]         rx_byte,
    input  logic               res_valid,
    input  logic               res_ready,
    input  logic [2:0]         status,
    input  logic [31:0]        load_value,
    input  logic               switch_on,
    output int unsigned        mismatch_count,
    output int unsigned        replies_pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] load_value;
        logic        switch_on;
    } reply_t;

    reply_t      replies_due [$];

    // Shadow of the registers and of the frame parser
    cfg_t        cfg;
    phase_t      ph;
    logic [3:0]  pos;
    logic [15:0] crc_acc;
    logic        is_load;
    logic [31:0] body;
    logic [7:0]  crc_lo;

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
        end
        return r;
    endfunction

    task automatic restart_hunt();
        ph      = PH_HUNT;
        pos     = '0;
        crc_acc = CRC_INIT;
        is_load = 1'b0;
        body    = '0;
        crc_lo  = '0;
    endtask

    task automatic push_reply(input logic [2:0] st, input logic [31:0] lv, input logic sw);
        reply_t r;
        r.status     = st;
        r.load_value = lv;
        r.switch_on  = sw;
        replies_due.push_back(r);
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        logic [3:0]  flen;
        logic [31:0] ld;
        case (ph)
            PH_CODE:
            begin
                crc_acc = crc16_step(crc_acc, b);
                if (b == cfg.switch_code || b == cfg.load_code)
                begin
                    // switch code wins when both codes are equal
                    is_load = (b != cfg.switch_code);
                    ph      = PH_BODY;
                    pos     = 4'd2;
                end
                else
                begin
                    push_reply(ST_UNKNOWN, '0, 1'b0);
                    restart_hunt();
                end
            end
            PH_BODY:
            begin
                flen = is_load ? LOAD_FRAME_LEN : SWITCH_FRAME_LEN;
                if (pos < flen - 4'd2)
                begin
                    crc_acc = crc16_step(crc_acc, b);
                    body    = {body[23:0], b};
                    pos     = pos + 4'd1;
                end
                else if (pos == flen - 4'd2)
                begin
                    crc_lo = b;
                    pos    = pos + 4'd1;
                end
                else if (pos == flen - 4'd1)
                begin
                    if ({b, crc_lo} != crc_acc)
                        push_reply(ST_CRC_ERROR, '0, 1'b0);
                    else if (is_load)
                    begin
                        // body holds d3..d6; load is word-swapped
                        ld = {body[15:8], body[7:0], body[31:24], body[23:16]};
                        push_reply(ST_LOAD_OK, (ld > LOAD_LIMIT) ? '0 : ld, 1'b0);
                    end
                    else if (body[7:0] == SWITCH_ON_VALUE)
                        push_reply(ST_SWITCH_ON, '0, 1'b1);
                    else if (body[7:0] == 8'h00)
                        push_reply(ST_SWITCH_OFF, '0, 1'b0);
                    else
                        push_reply(ST_BAD_SWITCH, '0, 1'b0);
                    restart_hunt();
                end
                else
                    restart_hunt();
            end
            default:
            begin
                restart_hunt();
                if (b == cfg.device_address)
                begin
                    crc_acc = crc16_step(CRC_INIT, b);
                    ph      = PH_CODE;
                    pos     = 4'd1;
                end
            end
        endcase
    endtask

    task automatic check_reply();
        reply_t want;
        if (replies_due.size() == 0)
        begin
            $error("unexpected result: status %0d load_value 0x%08h switch_on %0d",
                   status, load_value, switch_on);
            mismatch_count++;
        end
        else
        begin
            want = replies_due.pop_front();
            if (status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, status);
                mismatch_count++;
            end
            if (load_value !== want.load_value)
            begin
                $error("load_value: expected 0x%08h, got 0x%08h", want.load_value, load_value);
                mismatch_count++;
            end
            if (switch_on !== want.switch_on)
            begin
                $error("switch_on: expected %0d, got %0d", want.switch_on, switch_on);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.device_address = DEVICE_ADDRESS_RESET;
            cfg.load_code      = LOAD_CODE_RESET;
            cfg.switch_code    = SWITCH_CODE_RESET;
            restart_hunt();
            replies_due.delete();
        end
        else
        begin
            if (res_valid && res_ready)
                check_reply();
            // a byte taken at the same edge as a write still sees the old value
            if (rx_valid && rx_ready)
                parse_rx_byte(rx_byte);
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_DEVICE_ADDRESS: cfg.device_address = cfg_data;
                    CFG_LOAD_CODE:      cfg.load_code      = cfg_data;
                    CFG_SWITCH_CODE:    cfg.switch_code    = cfg_data;
                    default:            ;
                endcase
            end
        end
        replies_pending = replies_due.size();
    end

endmodule

@@ bench/tb_modbus_response_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus reply parser testbench
// Feeds well-formed switch and load replies, corrupted and cut frames,
// unknown codes and line noise under several register settings, with random
// gaps and stalls on both channels and one long result hold-off.
// ----------------------------------------------------------------------------

module tb_modbus_response_parser;

    import mrp_pkg::*;

    localparam int unsigned ITEMS_PER_PHASE = 217;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned IDLE_LIMIT      = 4000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write_en;
    logic [CfgIdxW-1:0] cfg_index;
    logic [7:0]         cfg_data;
    logic               rx_valid;
    logic               rx_ready;
    logic [7:0]         rx_byte;
    logic               res_valid;
    logic               res_ready;
    logic [2:0]         status;
    logic [31:0]        load_value;
    logic               switch_on;

    int unsigned        mismatch_count;
    int unsigned        replies_pending;

    // Register values the frame builder currently uses
    logic [7:0]         addr_q;
    logic [7:0]         load_q;
    logic [7:0]         switch_q;

    int unsigned        sent       = 0;
    int unsigned        burst_left = 0;
    int unsigned        quiet      = 0;
    bit                 tx_calm    = 1'b0;
    bit                 hold_off_req = 1'b0;

    always #5 clk = ~clk;

    modbus_response_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .status       (status),
        .load_value   (load_value),
        .switch_on    (switch_on)
    );

    modbus_response_parser_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rx_valid        (rx_valid),
        .rx_ready        (rx_ready),
        .rx_byte         (rx_byte),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .status          (status),
        .load_value      (load_value),
        .switch_on       (switch_on),
        .mismatch_count  (mismatch_count),
        .replies_pending (replies_pending)
    );

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = (tx_calm || burst_left > 0) ? 0 : $urandom_range(0, 14);
        if (burst_left > 0)
            burst_left--;
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        sent++;
        if (sent % 32 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
    endtask

    // cut = 0 sends the whole frame, else only its first cut bytes
    task automatic send_frame(input logic [7:0] code, input bit long_frame,
                              input logic [31:0] ld, input logic [7:0] sv,
                              input int unsigned cut, input bit corrupt);
        logic [7:0]  fb [0:8];
        logic [15:0] c;
        int unsigned n;
        int unsigned last;
        int          i;
        n     = long_frame ? 9 : 6;
        fb[0] = addr_q;
        fb[1] = code;
        for (i = 2; i < 9; i++)
            fb[i] = 8'($urandom);
        if (long_frame)
        begin
            fb[3] = ld[15:8];
            fb[4] = ld[7:0];
            fb[5] = ld[31:24];
            fb[6] = ld[23:16];
        end
        else
            fb[3] = sv;
        c = CRC_INIT;
        for (i = 0; i < n - 2; i++)
        begin
            c = c ^ {8'h00, fb[i]};
            repeat (8)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
            end
        end
        fb[n-2] = c[7:0];
        fb[n-1] = c[15:8];
        // single bit flip: always caught by the CRC
        if (corrupt)
            fb[$urandom_range(2, n - 1)] ^= 8'h01 << $urandom_range(0, 7);
        last = (cut != 0) ? cut : n;
        for (i = 0; i < last; i++)
            send_byte(fb[i]);
    endtask

    task automatic random_unit();
        int unsigned pick;
        logic [7:0]  uc;
        logic [31:0] ld;
        logic [7:0]  sv;
        bit          lf;
        pick = $urandom_range(0, 99);
        lf   = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       ld = '0;
            1:       ld = LOAD_LIMIT;
            2:       ld = LOAD_LIMIT + 32'd1;
            3:       ld = '1;
            default: ld = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0, 1:    sv = 8'h00;
            2, 3:    sv = SWITCH_ON_VALUE;
            default: sv = 8'($urandom);
        endcase
        if (pick < 30)
            send_frame(switch_q, 1'b0, ld, sv, 0, 1'b0);
        else if (pick < 62)
            send_frame(load_q, 1'b1, ld, sv, 0, 1'b0);
        else if (pick < 72)
            send_frame(lf ? load_q : switch_q, lf, ld, sv, 0, 1'b1);
        else if (pick < 80)
        begin
            do
                uc = 8'($urandom);
            while (uc == switch_q || uc == load_q);
            send_byte(addr_q);
            send_byte(uc);
        end
        else if (pick < 90)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        else
            send_frame(lf ? load_q : switch_q, lf, ld, sv,
                       $urandom_range(1, lf ? 8 : 5), 1'b0);
    endtask

    task automatic put_config(input logic [7:0] a, input logic [7:0] l, input logic [7:0] s);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_DEVICE_ADDRESS;
        cfg_data     <= a;
        @(posedge clk);
        cfg_index    <= CFG_LOAD_CODE;
        cfg_data     <= l;
        @(posedge clk);
        cfg_index    <= CFG_SWITCH_CODE;
        cfg_data     <= s;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        addr_q   = a;
        load_q   = l;
        switch_q = s;
    endtask

    // Checker updates on the rising edge, so look at its count on the falling one
    task automatic drain();
        rx_valid <= 1'b0;
        do
            @(negedge clk);
        while (replies_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] a;
        logic [7:0] c;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_DEVICE_ADDRESS;
        cfg_data     = '0;
        rx_valid     = 1'b0;
        rx_byte      = '0;
        addr_q       = DEVICE_ADDRESS_RESET;
        load_q       = LOAD_CODE_RESET;
        switch_q     = SWITCH_CODE_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: noise extremes, switch on, unknown code, load just over
        // the limit, switch frame with a bad CRC
        send_byte(8'hFF);
        send_byte(8'h00);
        send_frame(switch_q, 1'b0, '0, SWITCH_ON_VALUE, 0, 1'b0);
        send_byte(addr_q);
        send_byte(8'hFF);
        send_frame(load_q, 1'b1, LOAD_LIMIT + 32'd1, 8'h00, 0, 1'b0);
        send_frame(switch_q, 1'b0, '0, 8'h00, 0, 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                1: put_config(8'hFF, 8'h00, 8'hFF);
                2: put_config(8'h00, 8'hFF, 8'h00);
                3:
                begin
                    // equal codes: switch frame takes precedence
                    a = 8'($urandom);
                    c = 8'($urandom);
                    put_config(a, c, c);
                end
                4: put_config(8'($urandom), 8'($urandom), 8'($urandom));
                5: put_config(8'h11, 8'h04, 8'h01);
                default: ;
            endcase
            if (p == 2)
            begin
                hold_off_req = 1'b1;
                burst_left   = 60;
            end
            while (sent < (p + 1) * ITEMS_PER_PHASE)
                random_unit();
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && replies_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side: random stalls, calm stretches, one long hold-off
    initial
    begin
        int unsigned stall;
        int unsigned taken;
        bit          calm;
        bit          held;
        res_ready = 1'b0;
        taken     = 0;
        calm      = 1'b0;
        held      = 1'b0;
        do
            @(posedge clk);
        while (rst_n !== 1'b1);
        forever
        begin
            if (hold_off_req && !held)
            begin
                held = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_valid);
            taken++;
            if (taken % 24 == 0)
                calm = ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog: too long without any transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (rx_valid && rx_ready) || (res_valid && res_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/mrp_pkg.sv
hw/rtl/mrp_front.sv
hw/rtl/mrp_fifo.sv
hw/rtl/mrp_back.sv
hw/rtl/modbus_response_parser.sv
hw/rtl/mrp_checker.sv
bench/modbus_response_parser_checker.sv
bench/tb_modbus_response_parser.sv
